FILE: rtl/core/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation block.
// No dependencies; included by the files that assert.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication
`define MEXP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("modular_exponentiation: same-cycle check failed");

// next-cycle implication
`define MEXP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("modular_exponentiation: next-cycle check failed");

`endif

FILE: rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`default_nettype none
package mexp_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 32;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT_REDUCE,
        OP_INIT_ACC,
        OP_INIT_SQR,
        OP_STEP,
        OP_WB_SQ,
        OP_WB_ACC,
        OP_WB_SQR_SHIFT,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_lsb;
        logic mod_zero;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/mexp_datapath.sv
// Datapath: operand registers and a bit-serial modular multiplier/reducer.
// Depends on mexp_pkg; driven by mexp_controller.
`default_nettype none
module mexp_datapath #(
    parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                     aclk,
    input  wire mexp_pkg::dp_cmd_t        cmd,
    output      mexp_pkg::dp_status_t     status,
    input  wire logic [OPERAND_WIDTH-1:0] in_base,
    input  wire logic [OPERAND_WIDTH-1:0] in_exponent,
    input  wire logic [OPERAND_WIDTH-1:0] in_modulus,
    output      logic [OPERAND_WIDTH-1:0] power_result,
    output      logic                     zero_modulus_error
);
    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] base_reg, exp_reg, mod_reg, acc_reg, sq_reg;
    logic [W-1:0] a_reg, b_reg, r_reg;
    logic         reduce_reg;
    logic [W-1:0] out_data_reg;
    logic         out_err_reg;

    logic [W:0]   t1, t2;
    logic [W-1:0] r1, r2, addend;

    // one bit of a*b mod m (or b mod m when reducing), MSB first
    always_comb begin
        t1     = {r_reg, reduce_reg & b_reg[W-1]};
        r1     = (t1 >= {1'b0, mod_reg}) ? W'(t1 - {1'b0, mod_reg}) : t1[W-1:0];
        addend = (!reduce_reg && b_reg[W-1]) ? a_reg : '0;
        t2     = {1'b0, r1} + {1'b0, addend};
        r2     = (t2 >= {1'b0, mod_reg}) ? W'(t2 - {1'b0, mod_reg}) : t2[W-1:0];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                base_reg <= in_base;
                exp_reg  <= in_exponent;
                mod_reg  <= in_modulus;
                acc_reg  <= (in_modulus == W'(1)) ? '0 : W'(1);
            end
            OP_INIT_REDUCE: begin
                r_reg      <= '0;
                reduce_reg <= 1'b1;
                b_reg      <= base_reg;
            end
            OP_INIT_ACC: begin
                r_reg      <= '0;
                reduce_reg <= 1'b0;
                a_reg      <= sq_reg;
                b_reg      <= acc_reg;
            end
            OP_INIT_SQR: begin
                r_reg      <= '0;
                reduce_reg <= 1'b0;
                a_reg      <= sq_reg;
                b_reg      <= sq_reg;
            end
            OP_STEP: begin
                r_reg <= r2;
                b_reg <= {b_reg[W-2:0], 1'b0};
            end
            OP_WB_SQ:  sq_reg  <= r_reg;
            OP_WB_ACC: acc_reg <= r_reg;
            OP_WB_SQR_SHIFT: begin
                sq_reg  <= r_reg;
                exp_reg <= {1'b0, exp_reg[W-1:1]};
            end
            OP_PUBLISH: begin
                out_data_reg <= (mod_reg == '0) ? '0 : acc_reg;
                out_err_reg  <= (mod_reg == '0);
            end
            default: ;
        endcase
    end

    assign status.exp_lsb    = exp_reg[0];
    assign status.mod_zero   = (mod_reg == '0);
    assign power_result       = out_data_reg;
    assign zero_modulus_error = out_err_reg;

endmodule
`default_nettype wire

FILE: rtl/core/mexp_controller.sv
// Controller: sequences reduce, multiply and square passes and the handshakes.
// Depends on mexp_pkg; drives mexp_datapath.
`default_nettype none
module mexp_controller #(
    parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      mexp_pkg::dp_cmd_t    cmd,
    input  wire mexp_pkg::dp_status_t status
);
    import mexp_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_REDUCE,
        ST_REDUCE_WB,
        ST_DECIDE,
        ST_MUL,
        ST_MUL_WB,
        ST_SQR_INIT,
        ST_SQR,
        ST_SQR_WB,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             out_valid_reg, out_valid_next;
    dp_op_t           op;

    always_comb begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        op             = OP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.mod_zero) begin
                    state_next = ST_DONE;
                end else begin
                    op            = OP_INIT_REDUCE;
                    step_cnt_next = '0;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                op            = OP_STEP;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST) state_next = ST_REDUCE_WB;
            end
            ST_REDUCE_WB: begin
                op           = OP_WB_SQ;
                bit_cnt_next = '0;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                step_cnt_next = '0;
                if (status.exp_lsb) begin
                    op         = OP_INIT_ACC;
                    state_next = ST_MUL;
                end else begin
                    op         = OP_INIT_SQR;
                    state_next = ST_SQR;
                end
            end
            ST_MUL: begin
                op            = OP_STEP;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST) state_next = ST_MUL_WB;
            end
            ST_MUL_WB: begin
                op         = OP_WB_ACC;
                state_next = ST_SQR_INIT;
            end
            ST_SQR_INIT: begin
                op            = OP_INIT_SQR;
                step_cnt_next = '0;
                state_next    = ST_SQR;
            end
            ST_SQR: begin
                op            = OP_STEP;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST) state_next = ST_SQR_WB;
            end
            ST_SQR_WB: begin
                op           = OP_WB_SQR_SHIFT;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                state_next   = (bit_cnt_reg == LAST) ? ST_DONE : ST_DECIDE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    op             = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign cmd.op   = op;

endmodule
`default_nettype wire

FILE: rtl/core/modular_exponentiation.sv
// Channel   Ports            Payload
// request   s_t*  (in)       base, exponent, modulus
// result    m_t*  (out)      power result, zero-modulus flag
//
// After its request is accepted, a result passes through a start state, a bit-serial reduce
// of the base and its write-back, then per exponent bit a decide state and a bit-serial square
// with write-back, plus a bit-serial multiply with write-back and setup when the bit is set,
// then a publish state. s_tready rises with m_tvalid. A zero modulus goes from the start state
// straight to the publish state. aresetn is synchronous, active low. Only an untaken prior
// result stalls the block, in its final state.
`default_nettype none
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_tvalid,
    output      logic                                       s_tready,
    // base_value, exponent_value, modulus_value, zero pad
    input  wire logic [((3*OPERAND_WIDTH+7)/8)*8-1:0]        s_tdata,
    output      logic                                       m_tvalid,
    input  wire logic                                       m_tready,
    // power_result, zero pad
    output      logic [((OPERAND_WIDTH+7)/8)*8-1:0]          m_tdata,
    // zero_modulus_error
    output      logic [0:0]                                 m_tuser
);
    import mexp_pkg::*;

    localparam int W       = OPERAND_WIDTH;
    localparam int M_DATA_W = ((W + 7) / 8) * 8;

    dp_cmd_t      cmd;
    dp_status_t   status;
    logic [W-1:0] power_result;
    logic         zero_modulus_error;

    mexp_controller #(.OPERAND_WIDTH(W)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mexp_datapath #(.OPERAND_WIDTH(W)) u_dp (
        .aclk               (aclk),
        .cmd                (cmd),
        .status             (status),
        .in_base            (s_tdata[W-1:0]),
        .in_exponent        (s_tdata[2*W-1:W]),
        .in_modulus         (s_tdata[3*W-1:2*W]),
        .power_result       (power_result),
        .zero_modulus_error (zero_modulus_error)
    );

    assign m_tdata = M_DATA_W'(power_result);
    assign m_tuser = zero_modulus_error;

endmodule
`default_nettype wire

FILE: rtl/core/mexp_checker.sv
// Port-level checks for modular_exponentiation, bound to the top level.
// Depends on modular_exponentiation_assert.svh and mexp_pkg.
`default_nettype none
`include "modular_exponentiation_assert.svh"
module mexp_checker #(
    parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((OPERAND_WIDTH+7)/8)*8-1:0]    m_tdata,
    input wire logic [0:0]                           m_tuser
);
    logic                                  out_wait;
    logic [((OPERAND_WIDTH+7)/8)*8:0]      out_word;

    assign out_wait = m_tvalid && !m_tready;
    assign out_word = {m_tuser, m_tdata};

    `MEXP_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_wait, m_tvalid && $stable(out_word))
    `MEXP_ASSERT_IMPL(a_drop_only_on_take, aclk, aresetn, $fell(m_tvalid), $past(m_tready))
    `MEXP_ASSERT_IMPL(a_err_zero_result, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `MEXP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind modular_exponentiation mexp_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_mexp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

FILE: tb/modular_exponentiation_checker.sv
`timescale 1ns / 1ps
// Checker for modular_exponentiation: watches both stream channels, predicts each result
// by square-and-multiply, and compares in order. Depends on mexp_pkg for the operand width.
module modular_exponentiation_checker #(
    parameter int OPW = mexp_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [((3*OPW+7)/8)*8-1:0]        s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [((OPW+7)/8)*8-1:0]          m_tdata,
    input  wire logic [0:0]                        m_tuser,
    output int unsigned                            mismatch_count,
    output int unsigned                            pending_results
);

    typedef struct packed {
        logic [OPW-1:0] base;
        logic [OPW-1:0] expo;
        logic [OPW-1:0] modulus;
        logic [OPW-1:0] power;
        logic           zero_mod;
    } power_rec_t;

    power_rec_t expected_powers[$];

    function automatic power_rec_t predict_power(input logic [OPW-1:0] base,
                                                 input logic [OPW-1:0] expo,
                                                 input logic [OPW-1:0] modulus);
        power_rec_t      rec;
        logic [2*OPW-1:0] acc;
        logic [2*OPW-1:0] sq;
        logic [2*OPW-1:0] m;
        rec.base = base;
        rec.expo = expo;
        rec.modulus = modulus;
        if (modulus == '0) begin
            rec.power = '0;
            rec.zero_mod = 1'b1;
            return rec;
        end
        m = {{OPW{1'b0}}, modulus};
        acc = 1 % m;
        sq = {{OPW{1'b0}}, base} % m;
        for (int b = 0; b < OPW; b++) begin
            if (expo[b]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        rec.power = acc[OPW-1:0];
        rec.zero_mod = 1'b0;
        return rec;
    endfunction

    task automatic report_mismatch(input string what, input power_rec_t want);
        $display("%0t ns: %s (base %h exp %h mod %h)", $time, what,
                 want.base, want.expo, want.modulus);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        power_rec_t want;
        if (!aresetn) begin
            expected_powers.delete();
            mismatch_count = 0;
            pending_results = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_powers.push_back(predict_power(s_tdata[OPW-1:0],
                                                        s_tdata[2*OPW-1:OPW],
                                                        s_tdata[3*OPW-1:2*OPW]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_powers.size() == 0) begin
                    $display("%0t ns: result %h/%b with no request outstanding",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_powers.pop_front();
                    if (m_tdata[OPW-1:0] !== want.power) begin
                        report_mismatch($sformatf("power_result got %h want %h",
                                                  m_tdata[OPW-1:0], want.power), want);
                    end
                    if (m_tuser[0] !== want.zero_mod) begin
                        report_mismatch($sformatf("zero_modulus_error got %b want %b",
                                                  m_tuser[0], want.zero_mod), want);
                    end
                end
            end
            pending_results = expected_powers.size();
        end
    end

endmodule

FILE: tb/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// Top of the modular_exponentiation testbench: clock, reset, request stimulus and result
// back-pressure, with the checker beside the block. Depends on mexp_pkg and the checker.
module modular_exponentiation_tb;

    localparam int OPW = mexp_pkg::DEFAULT_OPERAND_WIDTH;
    localparam int S_BITS = ((3*OPW+7)/8)*8;
    localparam int M_BITS = ((OPW+7)/8)*8;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int BUSY_CYCLES = OPW*(2*OPW+5)+OPW+4;
    localparam int PHASE_REQUESTS = 67;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_BITS-1:0]   s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_BITS-1:0]   m_tdata;
    logic [0:0]          m_tuser;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned cycle_count = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned rx_hold_cycles = 0;
    int unsigned requests_sent = 0;
    int unsigned zero_mod_sent = 0;

    modular_exponentiation #(
        .OPERAND_WIDTH(OPW)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    modular_exponentiation_checker #(
        .OPW(OPW)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result back-pressure; a long hold-off overrides the random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles != 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic send_request(input logic [OPW-1:0] base,
                                input logic [OPW-1:0] expo,
                                input logic [OPW-1:0] modulus);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // occasional long gap so a request lands at any point of the block's work
        if (snd_idle_pct != 0 && $urandom_range(99) < 5) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, BUSY_CYCLES + 100)) @(posedge aclk);
        end
        s_tdata <= {modulus, expo, base};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        if (modulus == '0) zero_mod_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    function automatic logic [OPW-1:0] pick_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return OPW'($urandom_range(2, 255));
            4: return OPW'($urandom_range(0, 65535));
            5: return '1 - OPW'($urandom_range(0, 255));
            default: return OPW'($urandom);
        endcase
    endfunction

    function automatic logic [OPW-1:0] pick_modulus();
        logic [OPW-1:0] m;
        if ($urandom_range(99) < 4) return '0;
        m = pick_operand();
        return (m == '0) ? OPW'($urandom) | 1 : m;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_request(pick_operand(), pick_operand(), pick_modulus());
    endtask

    initial begin
        int unsigned snd_pcts[4] = '{0, 67, 0, 17};
        int unsigned rcv_pcts[4] = '{0, 0, 67, 17};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // operand extremes and the special cases
        send_request('0, '0, '0);
        send_request('1, '1, '0);
        send_request(32'd5, 32'd3, '0);
        send_request(32'd7, '0, 32'd1);
        send_request(32'd7, '0, 32'd13);
        send_request('0, '0, '1);
        send_request('0, 32'd9, 32'd11);
        send_request(32'd3, 32'd1, 32'd2);
        send_request(32'd100, 32'd1, 32'd7);
        send_request('1, '1, '1);
        send_request('1 - 1, '1, '1);
        send_request(32'd2, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
        send_request(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'd1);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        send_request(32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAB);
        send_request(32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            snd_idle_pct = snd_pcts[p];
            rcv_stall_pct = rcv_pcts[p];
            send_random(PHASE_REQUESTS);
            wait_drained();
        end

        // hold results back long enough that the block fills and stalls requests
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        rx_hold_cycles = 4 * BUSY_CYCLES;
        send_random(6);
        wait_drained();

        repeat (BUSY_CYCLES + 50) @(posedge aclk);
        $display("Covered %0d requests (%0d with zero modulus) over directed, idle-mix",
                 requests_sent, zero_mod_sent);
        $display("and back-pressure phases; %0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_datapath.sv
rtl/core/mexp_controller.sv
rtl/core/modular_exponentiation.sv
rtl/core/mexp_checker.sv
tb/modular_exponentiation_checker.sv
tb/modular_exponentiation_tb.sv
